[rtl/tlvx_pkg.sv]
package tlvx_pkg;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_TRAILER = 2'd2;
    localparam logic [1:0] PH_DONE    = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SHORT  = 2'd1;
    localparam logic [1:0] ST_BADSUM = 2'd2;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [7:0]  type_code;
        logic [23:0] payload_length;
        logic [1:0]  status;
        logic        last_of_run;
    } result_t;

    // up to two results per input word, first one in r0
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } parse_out_t;

endpackage

[rtl/tlvx_parser.sv]
module tlvx_parser
    import tlvx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_take,
    input  logic [7:0] in_byte,
    input  logic       end_of_buffer,
    output parse_out_t res
);

    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  header_count_reg, header_count_next;
    logic [7:0]  captured_type_reg, captured_type_next;
    logic [23:0] frame_length_reg, frame_length_next;
    logic [23:0] payload_seen_reg, payload_seen_next;
    logic [31:0] check_lanes_reg, check_lanes_next;
    logic [1:0]  lane_index_reg, lane_index_next;
    logic [1:0]  trailer_count_reg, trailer_count_next;
    logic        mismatch_seen_reg, mismatch_seen_next;

    logic        pay_v;
    logic        fin_v;
    logic [1:0]  fin_status;
    logic        short_v;
    logic [31:0] byte_wide;
    logic [7:0]  lane_sel;
    result_t     pay_r;
    result_t     stat_r;

    assign byte_wide = {24'd0, in_byte};

    always_comb
    begin
        phase_next         = phase_reg;
        header_count_next  = header_count_reg;
        captured_type_next = captured_type_reg;
        frame_length_next  = frame_length_reg;
        payload_seen_next  = payload_seen_reg;
        check_lanes_next   = check_lanes_reg;
        lane_index_next    = lane_index_reg;
        trailer_count_next = trailer_count_reg;
        mismatch_seen_next = mismatch_seen_reg;
        pay_v      = 1'b0;
        fin_v      = 1'b0;
        fin_status = ST_OK;
        lane_sel   = 8'(check_lanes_reg >> {trailer_count_reg, 3'b000});

        case (phase_reg)
            PH_HEADER:
            begin
                check_lanes_next = check_lanes_reg | (byte_wide << {header_count_reg, 3'b000});
                case (header_count_reg)
                    2'd0:    captured_type_next = in_byte;
                    2'd1:    frame_length_next[23:16] = in_byte;
                    2'd2:    frame_length_next[15:8]  = in_byte;
                    default: frame_length_next[7:0]   = in_byte;
                endcase
                header_count_next = header_count_reg + 2'd1;
                if (header_count_reg == 2'd3)
                begin
                    phase_next = (frame_length_next == 24'd0) ? PH_TRAILER : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                check_lanes_next  = check_lanes_reg ^ (byte_wide << {lane_index_reg, 3'b000});
                lane_index_next   = lane_index_reg + 2'd1;
                payload_seen_next = payload_seen_reg + 24'd1;
                pay_v = 1'b1;
                if (payload_seen_next == frame_length_reg)
                begin
                    phase_next = PH_TRAILER;
                end
            end
            PH_TRAILER:
            begin
                if (lane_sel != in_byte)
                begin
                    mismatch_seen_next = 1'b1;
                end
                trailer_count_next = trailer_count_reg + 2'd1;
                if (trailer_count_reg == 2'd3)
                begin
                    phase_next = PH_DONE;
                    fin_v      = 1'b1;
                    fin_status = mismatch_seen_next ? ST_BADSUM : ST_OK;
                end
            end
            default:
            begin
            end
        endcase

        short_v = !fin_v && end_of_buffer && (phase_next != PH_DONE);

        pay_r.kind           = KIND_PAYLOAD;
        pay_r.payload_byte   = in_byte;
        pay_r.type_code      = captured_type_next;
        pay_r.payload_length = frame_length_next;
        pay_r.status         = ST_OK;
        pay_r.last_of_run    = !(fin_v || short_v);

        stat_r.kind           = KIND_STATUS;
        stat_r.payload_byte   = 8'd0;
        stat_r.type_code      = captured_type_next;
        stat_r.payload_length = frame_length_next;
        stat_r.status         = fin_v ? fin_status : ST_SHORT;
        stat_r.last_of_run    = 1'b1;

        // status goes in the first slot when no payload word comes before it
        res.v0 = pay_v || fin_v || short_v;
        res.v1 = pay_v && (fin_v || short_v);
        res.r0 = pay_v ? pay_r : stat_r;
        res.r1 = stat_r;

        if (end_of_buffer)
        begin
            phase_next         = PH_HEADER;
            header_count_next  = 2'd0;
            captured_type_next = 8'd0;
            frame_length_next  = 24'd0;
            payload_seen_next  = 24'd0;
            check_lanes_next   = 32'd0;
            lane_index_next    = 2'd0;
            trailer_count_next = 2'd0;
            mismatch_seen_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HEADER;
            header_count_reg  <= 2'd0;
            captured_type_reg <= 8'd0;
            frame_length_reg  <= 24'd0;
            payload_seen_reg  <= 24'd0;
            check_lanes_reg   <= 32'd0;
            lane_index_reg    <= 2'd0;
            trailer_count_reg <= 2'd0;
            mismatch_seen_reg <= 1'b0;
        end
        else if (in_take)
        begin
            phase_reg         <= phase_next;
            header_count_reg  <= header_count_next;
            captured_type_reg <= captured_type_next;
            frame_length_reg  <= frame_length_next;
            payload_seen_reg  <= payload_seen_next;
            check_lanes_reg   <= check_lanes_next;
            lane_index_reg    <= lane_index_next;
            trailer_count_reg <= trailer_count_next;
            mismatch_seen_reg <= mismatch_seen_next;
        end
    end

endmodule

[rtl/tlvx_out_fifo.sv]
module tlvx_out_fifo
    import tlvx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  parse_out_t wr,
    output logic       room2,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_data
);

    result_t    mem [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;
    logic       w0;
    logic       w1;
    logic [1:0] wr_ptr_p1;

    assign out_valid = (count_reg != 3'd0);
    assign out_data  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // two free slots cover the worst case of one word
    assign room2     = (count_reg <= 3'd2);
    assign w0        = push && wr.v0;
    assign w1        = push && wr.v1;
    assign wr_ptr_p1 = wr_ptr_reg + 2'd1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + {1'b0, w0} + {1'b0, w1};
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {2'b00, w0} + {2'b00, w1} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (w0)
        begin
            mem[wr_ptr_reg] <= wr.r0;
        end
        if (w1)
        begin
            mem[wr_ptr_p1] <= wr.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/tlv_xor_frame_decoder.sv]
// Channel   Direction  tdata                                     tuser  tlast
// s_axis    in         [7:0] in_byte                             -      end_of_buffer
// m_axis    out        [7:0] payload_byte, [15:8] type_code,     kind   last_of_run
//                      [39:16] payload_length, [41:40] status
//
// One input word per cycle while two queue slots are free; each word is parsed
// in the cycle it is taken and its results, up to two, are written to a
// 4-entry output queue whose head drives m_axis. s_axis_tready depends only on the
// queue fill (two free slots), never on m_axis_tready combinationally.
// A stall on m_axis fills the queue; input resumes once two slots are free.
// rst_n clears the parse state and empties the queue.
module tlv_xor_frame_decoder
    import tlvx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // end_of_buffer
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] type_code,
                                        // [39:16] payload_length, [41:40] status
    output logic        m_axis_tuser,   // kind
    output logic        m_axis_tlast    // last_of_run
);

    logic       take;
    logic       room2;
    parse_out_t res;
    result_t    head;

    assign s_axis_tready = room2;
    assign take          = s_axis_tvalid && room2;

    tlvx_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_take       (take),
        .in_byte       (s_axis_tdata),
        .end_of_buffer (s_axis_tlast),
        .res           (res)
    );

    tlvx_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .wr        (res),
        .room2     (room2),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (head)
    );

    assign m_axis_tdata = {6'd0, head.status, head.payload_length,
                           head.type_code, head.payload_byte};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last_of_run;

endmodule
